[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the pooling block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mp2d_pkg.sv]
// ----------------------------------------------------------------------------
// mp2d_pkg
// constants, types and helper functions of the streaming 2-d max pool
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_WINDOW  = 8;
    localparam int PIXEL_BITS  = 16;
    localparam int MAX_HEIGHT  = 4096;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LANE_W      = $clog2(MAX_WINDOW);
    localparam int WORD_W      = MAX_WINDOW * PIXEL_BITS;

    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int WIN_W       = 4;
    localparam int STEP_W      = 4;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;

    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = ROW_W + RECIP_W;

    localparam logic [FW_W-1:0]   FW_RESET  = FW_W'(1200);
    localparam logic [FH_W-1:0]   FH_RESET  = FH_W'(1200);
    localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(5);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_WINDOW_SIZE,
        CFG_STEP_SIZE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MERGE,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] quo;
        logic [ROW_W-1:0] rem;
    } t_divres;

    // floor(2^16 / d)
    function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21845;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13107;
            4'd6:    m = 17'd10922;
            4'd7:    m = 17'd9362;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7281;
            4'd10:   m = 17'd6553;
            4'd11:   m = 17'd5957;
            4'd12:   m = 17'd5461;
            4'd13:   m = 17'd5041;
            4'd14:   m = 17'd4681;
            4'd15:   m = 17'd4369;
            default: m = '0;
        endcase
        return m;
    endfunction

    // quotient estimate from the reciprocal product, then one correction step
    function automatic t_divres div_fix(input logic [ROW_W-1:0]  x,
                                        input logic [PROD_W-1:0] p,
                                        input logic [STEP_W-1:0] d);
        logic [ROW_W-1:0]        q;
        logic [ROW_W+STEP_W-1:0] back;
        logic [ROW_W-1:0]        r;
        t_divres                 res;
        q    = p[RECIP_SHIFT +: ROW_W];
        back = (ROW_W+STEP_W)'(q) * (ROW_W+STEP_W)'(d);
        r    = x - back[ROW_W-1:0];
        if (r >= ROW_W'(d)) begin
            q = q + ROW_W'(1);
            r = r - ROW_W'(d);
        end
        res.quo = q;
        res.rem = r;
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/mp2d_ram.sv]
// ----------------------------------------------------------------------------
// mp2d_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/max_pool_2d_stream.sv]
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// streaming 2-d max pooling over a raster frame of signed pixels
//
// pixels enter on the i_pixel_valid / o_pixel_ready channel in raster order,
// one transfer per pixel. results leave on o_pool_valid / i_pool_ready with
// the window maximum, its row and column in the pooled map and a frame_last
// flag. configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, and the
// user writes it between frames or while no pixel is in flight (not enforced).
// the line store is one ram of MAX_WIDTH words, each word holding one column
// of MAX_WINDOW rows; every pixel is a read-modify-write of its column word.
// a pixel that closes no window passes a read, a reciprocal multiply, and a
// merge and write back. a pixel that closes a window then goes through a read
// state, where the k window columns are read one word per cycle through the
// ram read port, and an emit state that loads the output register.
// an output register holds the result, so the next pixel is taken while it
// waits; if the receiver stalls and a new window closes, the block holds
// o_pixel_ready low until the pending result is transferred.
// reset clears positions and the output valid and restores the register
// defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_pixel_valid,
    output logic                                    o_pixel_ready,
    input  logic signed [mp2d_pkg::PIXEL_BITS-1:0]  i_pixel_value,
    output logic                                    o_pool_valid,
    input  logic                                    i_pool_ready,
    output logic signed [mp2d_pkg::PIXEL_BITS-1:0]  o_pooled_value,
    output logic        [mp2d_pkg::ROW_W-1:0]       o_out_row,
    output logic        [mp2d_pkg::COL_W-1:0]       o_out_column,
    output logic                                    o_frame_last,
    input  logic                                    i_cfg_we,
    input  logic        [mp2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [mp2d_pkg::CFG_W-1:0]       i_cfg_data
);

    import mp2d_pkg::*;

    // configuration
    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [WIN_W-1:0]  r_window_size;
    logic [STEP_W-1:0] r_step_size;

    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [WIN_W-1:0]  k_eff;
    logic [STEP_W-1:0] s_eff;

    // control
    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row_pos, n_row_pos;
    logic [COL_W-1:0]  r_col_pos, n_col_pos;
    logic [WIN_W-1:0]  r_j, n_j;
    logic              r_out_valid, n_out_valid;

    // per-pixel payload
    logic [ROW_W-1:0]             r_row, n_row;
    logic [COL_W-1:0]             r_col, n_col;
    logic signed [PIXEL_BITS-1:0] r_pix, n_pix;
    logic [ROW_W-1:0]             r_oy, n_oy;
    logic [COL_W-1:0]             r_ox, n_ox;
    logic                         r_cand, n_cand;
    logic [PROD_W-1:0]            r_p_lane, n_p_lane;
    logic [PROD_W-1:0]            r_p_oy, n_p_oy;
    logic [PROD_W-1:0]            r_p_ox, n_p_ox;
    logic [ROW_W-1:0]             r_orow, n_orow;
    logic [COL_W-1:0]             r_ocol, n_ocol;
    logic                         r_last, n_last;
    logic signed [PIXEL_BITS-1:0] r_acc, n_acc;
    logic signed [PIXEL_BITS-1:0] r_pooled, n_pooled;
    logic [ROW_W-1:0]             r_out_row, n_out_row;
    logic [COL_W-1:0]             r_out_col, n_out_col;
    logic                         r_out_last, n_out_last;

    // position wrap
    logic [ROW_W:0]    row_step;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic              col_end;
    logic              row_end;

    // merge stage
    t_divres           lane_res;
    t_divres           oy_res;
    t_divres           ox_res;
    logic [LANE_W-1:0] lane;
    logic              emit;
    logic [WORD_W-1:0] wr_word;

    // column max
    logic signed [PIXEL_BITS-1:0] lane_v;
    logic signed [PIXEL_BITS-1:0] colmax;

    // ram
    logic              ram_we;
    logic              ram_re;
    logic [COL_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rd;

    logic out_xfer;

    assign out_xfer = r_out_valid && i_pool_ready;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = FW_W'(1);
        end else if (r_frame_width > FW_W'(MAX_WIDTH)) begin
            w_eff = FW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = FH_W'(1);
        end else if (r_frame_height > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
        if (r_window_size == '0) begin
            k_eff = WIN_W'(1);
        end else if (r_window_size > WIN_W'(MAX_WINDOW)) begin
            k_eff = WIN_W'(MAX_WINDOW);
        end else begin
            k_eff = r_window_size;
        end
        s_eff = (r_step_size == '0) ? STEP_W'(1) : r_step_size;
    end

    always_comb begin
        if (FW_W'(r_col_pos) >= w_eff) begin
            cur_col  = '0;
            row_step = (ROW_W+1)'(r_row_pos) + (ROW_W+1)'(1);
        end else begin
            cur_col  = r_col_pos;
            row_step = (ROW_W+1)'(r_row_pos);
        end
        cur_row = (FH_W'(row_step) >= h_eff) ? '0 : row_step[ROW_W-1:0];
        col_end = (FW_W'(cur_col) + FW_W'(1)) >= w_eff;
        row_end = (FH_W'(cur_row) + FH_W'(1)) >= h_eff;
    end

    // finish the three divisions and merge the pixel into its column word
    always_comb begin
        lane_res = div_fix(r_row, r_p_lane, STEP_W'(k_eff));
        oy_res   = div_fix(r_oy, r_p_oy, s_eff);
        ox_res   = div_fix(ROW_W'(r_ox), r_p_ox, s_eff);
        lane     = lane_res.rem[LANE_W-1:0];
        emit     = r_cand && (oy_res.rem == '0) && (ox_res.rem == '0);
        for (int l = 0; l < MAX_WINDOW; l++) begin
            if (LANE_W'(l) == lane) begin
                wr_word[l*PIXEL_BITS +: PIXEL_BITS] = r_pix;
            end else begin
                wr_word[l*PIXEL_BITS +: PIXEL_BITS] = ram_rd[l*PIXEL_BITS +: PIXEL_BITS];
            end
        end
    end

    always_comb begin
        colmax = $signed(ram_rd[PIXEL_BITS-1:0]);
        lane_v = colmax;
        for (int l = 1; l < MAX_WINDOW; l++) begin
            lane_v = $signed(ram_rd[l*PIXEL_BITS +: PIXEL_BITS]);
            if ((WIN_W'(l) < k_eff) && (lane_v > colmax)) begin
                colmax = lane_v;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row_pos   = r_row_pos;
        n_col_pos   = r_col_pos;
        n_j         = r_j;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_row       = r_row;
        n_col       = r_col;
        n_pix       = r_pix;
        n_oy        = r_oy;
        n_ox        = r_ox;
        n_cand      = r_cand;
        n_p_lane    = r_p_lane;
        n_p_oy      = r_p_oy;
        n_p_ox      = r_p_ox;
        n_orow      = r_orow;
        n_ocol      = r_ocol;
        n_last      = r_last;
        n_acc       = r_acc;
        n_pooled    = r_pooled;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = cur_col;
        o_pixel_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_pixel_ready = 1'b1;
                if (i_pixel_valid) begin
                    ram_re = 1'b1;
                    n_row  = cur_row;
                    n_col  = cur_col;
                    n_pix  = i_pixel_value;
                    n_oy   = cur_row + ROW_W'(1) - ROW_W'(k_eff);
                    n_ox   = cur_col + COL_W'(1) - COL_W'(k_eff);
                    n_cand = ((FH_W'(cur_row) + FH_W'(1)) >= FH_W'(k_eff)) &&
                             ((FW_W'(cur_col) + FW_W'(1)) >= FW_W'(k_eff));
                    if (col_end) begin
                        n_col_pos = '0;
                        n_row_pos = row_end ? '0 : cur_row + ROW_W'(1);
                    end else begin
                        n_col_pos = cur_col + COL_W'(1);
                        n_row_pos = cur_row;
                    end
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_p_lane = PROD_W'(r_row) * PROD_W'(recip(STEP_W'(k_eff)));
                n_p_oy   = PROD_W'(r_oy) * PROD_W'(recip(s_eff));
                n_p_ox   = PROD_W'(r_ox) * PROD_W'(recip(s_eff));
                n_state  = S_MERGE;
            end
            S_MERGE: begin
                ram_we = 1'b1;
                n_orow = oy_res.quo;
                n_ocol = ox_res.quo[COL_W-1:0];
                n_last = ((FH_W'(r_oy) + FH_W'(s_eff)) > (h_eff - FH_W'(k_eff))) &&
                         ((FW_W'(r_ox) + FW_W'(s_eff)) > (w_eff - FW_W'(k_eff)));
                n_j     = '0;
                n_state = emit ? S_READ : S_IDLE;
            end
            S_READ: begin
                ram_raddr = r_ox + COL_W'(r_j);
                ram_re    = (r_j < k_eff);
                if (r_j != '0) begin
                    if ((r_j == WIN_W'(1)) || (colmax > r_acc)) begin
                        n_acc = colmax;
                    end
                end
                if (r_j == k_eff) begin
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + WIN_W'(1);
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_pool_ready) begin
                    n_out_valid = 1'b1;
                    n_pooled    = r_acc;
                    n_out_row   = r_orow;
                    n_out_col   = r_ocol;
                    n_out_last  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_window_size  <= WIN_RESET;
            r_step_size    <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                CFG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WIN_W-1:0];
                CFG_STEP_SIZE:    r_step_size    <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_pos   <= n_row_pos;
            r_col_pos   <= n_col_pos;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_pix      <= n_pix;
        r_oy       <= n_oy;
        r_ox       <= n_ox;
        r_cand     <= n_cand;
        r_p_lane   <= n_p_lane;
        r_p_oy     <= n_p_oy;
        r_p_ox     <= n_p_ox;
        r_orow     <= n_orow;
        r_ocol     <= n_ocol;
        r_last     <= n_last;
        r_acc      <= n_acc;
        r_pooled   <= n_pooled;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
    end

    // line store, one word per frame column, one lane per window row
    mp2d_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (wr_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    assign o_pool_valid   = r_out_valid;
    assign o_pooled_value = r_pooled;
    assign o_out_row      = r_out_row;
    assign o_out_column   = r_out_col;
    assign o_frame_last   = r_out_last;

endmodule

`default_nettype wire

[rtl/mp2d_checker.sv]
// ----------------------------------------------------------------------------
// mp2d_checker
// port-level checks on the pooling block, attached to the top level by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mp2d_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_pixel_valid,
    input logic                                    o_pixel_ready,
    input logic                                    o_pool_valid,
    input logic                                    i_pool_ready,
    input logic signed [mp2d_pkg::PIXEL_BITS-1:0]  o_pooled_value,
    input logic        [mp2d_pkg::ROW_W-1:0]       o_out_row,
    input logic        [mp2d_pkg::COL_W-1:0]       o_out_column,
    input logic                                    o_frame_last
);

    // a stalled result stays offered
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_pool_valid && !i_pool_ready |=> o_pool_valid, "result dropped before transfer")

    // a stalled result keeps its payload
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_pool_valid && !i_pool_ready |=> $stable(o_pooled_value) && $stable(o_out_row) && $stable(o_out_column) && $stable(o_frame_last), "result changed while stalled")

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_pool_valid, "result valid after reset")

    // one pixel in flight at a time
    `ASSERT_RST(a_one_pixel, i_clk, i_rst_n, i_pixel_valid && o_pixel_ready |=> !o_pixel_ready, "pixel taken while previous still in work")

endmodule

bind max_pool_2d_stream mp2d_checker u_mp2d_checker (.*);

`default_nettype wire
